FILE: rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and GF(256) helpers
// Beat structs, cell control group, controller states, field arithmetic.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam logic [8:0] GF_POLY      = 9'h11d;
    localparam int         PARITY_RESET = 10;
    localparam int         CFG_W        = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } rsp_in_t;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_out;
    } rsp_out_t;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic clear;   // zero remainder and coefficients
        logic derive;  // one generator multiplication step
        logic absorb;  // take a data beat
        logic load;    // data beat is last: copy remainder to emit row
        logic shift;   // output beat taken: advance emit row
    } rsp_ctrl_t;

    typedef enum logic {
        ST_DERIVE,
        ST_RUN
    } rsp_state_t;

    // multiply by alpha
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [8:0] s;
        s = {a, 1'b0};
        if (s[8])
        begin
            s = s ^ GF_POLY;
        end
        return s[7:0];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        return p;
    endfunction

endpackage

FILE: rtl/rsp_cell.sv
// ----------------------------------------------------------------------------
// rsp_cell: one stage of the parity row
// Holds one remainder byte, one generator coefficient and one emit byte.
// ----------------------------------------------------------------------------
module rsp_cell
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rsp_ctrl_t  ctrl,
    input  logic [7:0] factor,
    input  logic [7:0] root,
    input  logic [7:0] p_right,
    input  logic [7:0] e_right,
    input  logic [7:0] a_left,
    output logic [7:0] p,
    output logic [7:0] e,
    output logic [7:0] a
);

    logic [7:0] p_reg, p_next;
    logic [7:0] e_reg, e_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] prod;

    // two multipliers behind a mux: root times left neighbour while deriving, else coefficient times factor
    assign prod = ctrl.derive ? gf_mul(root, a_left) : gf_mul(a_reg, factor);

    always_comb
    begin
        p_next = p_reg;
        a_next = a_reg;
        e_next = e_reg;
        if (ctrl.clear)
        begin
            p_next = '0;
            a_next = '0;
        end
        else if (ctrl.derive)
        begin
            a_next = a_reg ^ prod;
        end
        else if (ctrl.absorb)
        begin
            p_next = ctrl.load ? 8'h00 : (p_right ^ prod);
        end
        if (ctrl.load)
        begin
            e_next = p_right ^ prod;
        end
        else if (ctrl.shift)
        begin
            e_next = e_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            a_reg <= '0;
        end
        else
        begin
            p_reg <= p_next;
            a_reg <= a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

    assign p = p_reg;
    assign e = e_reg;
    assign a = a_reg;

endmodule

FILE: rtl/rsp_ctrl.sv
// ----------------------------------------------------------------------------
// rsp_ctrl: sequencer for the parity row
// Generator derivation steps, input flow control and parity burst count.
// ----------------------------------------------------------------------------
module rsp_ctrl
    import rsp_pkg::*;
#(
    parameter int MAX_PARITY = 30
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             last_in,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             last_out,
    output rsp_ctrl_t        ctrl,
    output logic [7:0]       root
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int RESET_N_INT = (PARITY_RESET > MAX_PARITY) ? MAX_PARITY : PARITY_RESET;
    localparam logic [CW-1:0] RESET_N = CW'(RESET_N_INT);
    localparam logic [CW-1:0] ONE     = CW'(1);

    rsp_state_t    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [7:0]    root_reg, root_next;
    logic          ov_reg, ov_next;
    logic [CW-1:0] cfg_n;
    logic          out_beat, final_beat;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_n = ONE;
        end
        else if (int'(cfg_wr_data) > MAX_PARITY)
        begin
            cfg_n = CW'(MAX_PARITY);
        end
        else
        begin
            cfg_n = CW'(cfg_wr_data);
        end
    end

    assign out_beat   = ov_reg && out_ready;
    assign final_beat = out_beat && (rem_reg == ONE);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        root_next   = root_reg;
        rem_next    = rem_reg;
        ov_next     = ov_reg;
        ctrl        = '0;
        // a last beat waits until the emit row is free
        in_ready    = (state_reg == ST_RUN) && !(last_in && ov_reg && !final_beat);

        case (state_reg)
            ST_DERIVE:
            begin
                ctrl.derive = !cfg_wr_en;
                cnt_next    = cnt_reg + ONE;
                root_next   = gf_xtime(root_reg);
                if (cnt_reg == n_reg - ONE)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctrl.absorb = in_valid && in_ready;
                ctrl.load   = ctrl.absorb && last_in;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (ctrl.load)
        begin
            ov_next  = 1'b1;
            rem_next = n_reg;
        end
        else if (out_beat)
        begin
            ctrl.shift = 1'b1;
            rem_next   = rem_reg - ONE;
            ov_next    = !final_beat;
        end

        if (cfg_wr_en)
        begin
            ctrl.clear = 1'b1;
            n_next     = cfg_n;
            cnt_next   = '0;
            root_next  = 8'h01;
            state_next = ST_DERIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DERIVE;
            n_reg     <= RESET_N;
            cnt_reg   <= '0;
            root_reg  <= 8'h01;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            root_reg  <= root_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign last_out  = (rem_reg == ONE);
    assign root      = root_reg;

endmodule

FILE: rtl/reed_solomon_parity_encoder.sv
// Timing: a data beat is absorbed in the cycle it is accepted; the first parity
//   beat is valid the cycle after the last data beat.
// Throughput: one data beat per cycle when not deriving; the next block streams in
//   during a burst; its last beat waits only while the previous burst is in flight.
// Reset: the generator for the reset parity count (n=10) is derived one root at a
//   time, in_ready low meanwhile; every parity_count write repeats this.
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder: systematic RS parity over GF(256), poly 0x11d
// A row of MAX_PARITY cells forms the remainder register, the generator store
// and a separate emit shift row, so absorption and emission overlap.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder
    import rsp_pkg::*;
#(
    parameter int MAX_PARITY = 30
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  rsp_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_out_t         out_data
);

    rsp_ctrl_t  ctrl;
    logic [7:0] root;
    logic [7:0] factor;
    logic       last_out;

    // cell k: p = remainder term (k=0 highest order),
    //         a = generator coefficient g[n-1-k], zero beyond n,
    //         e = emit row, e[0] is the output register
    logic [7:0] p [MAX_PARITY];
    logic [7:0] e [MAX_PARITY];
    logic [7:0] a [MAX_PARITY];

    rsp_ctrl #(
        .MAX_PARITY (MAX_PARITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .last_in     (in_data.last_in),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .last_out    (last_out),
        .ctrl        (ctrl),
        .root        (root)
    );

    // feedback term, broadcast to every cell
    assign factor = in_data.data_byte ^ p[0];

    // Derivation multiplies by (x + alpha^i) once per step: each cell adds
    // its left neighbour times the root; the implicit leading 1 enters at cell 0.
    for (genvar k = 0; k < MAX_PARITY; k++)
    begin : g_cell
        logic [7:0] p_r, e_r, a_l;
        if (k == MAX_PARITY - 1)
        begin : g_tail
            assign p_r = 8'h00;
            assign e_r = 8'h00;
        end
        else
        begin : g_mid
            assign p_r = p[k+1];
            assign e_r = e[k+1];
        end
        if (k == 0)
        begin : g_head
            assign a_l = 8'h01;
        end
        else
        begin : g_link
            assign a_l = a[k-1];
        end

        rsp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .factor  (factor),
            .root    (root),
            .p_right (p_r),
            .e_right (e_r),
            .a_left  (a_l),
            .p       (p[k]),
            .e       (e[k]),
            .a       (a[k])
        );
    end

    assign out_data.parity_byte = e[0];
    assign out_data.last_out    = last_out;

endmodule

FILE: rtl/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker: port-level checks for the parity encoder
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
module rsp_checker
    import rsp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_wr_en,
    input logic [CFG_W-1:0] cfg_wr_data,
    input logic             in_valid,
    input logic             in_ready,
    input rsp_in_t          in_data,
    input logic             out_valid,
    input logic             out_ready,
    input rsp_out_t         out_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // generator derivation blocks input
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_ready)
        else $error("input ready during generator derivation");

    // last data beat starts a burst
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_in |=> out_valid)
        else $error("no parity burst after last data beat");

    // burst continues until its final beat
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_out |=> out_valid)
        else $error("parity burst ended early");

    // no new burst while one is still pending
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_in && out_valid
        |-> out_ready && out_data.last_out)
        else $error("last data beat accepted over a pending burst");

endmodule

bind reed_solomon_parity_encoder rsp_checker u_rsp_checker (.*);
